// File: rtl/vipc_pkg.sv
// vipc_pkg: shared widths, codes and types for the vector index pattern classifier
// no dependencies; used by vipc_stats and vector_index_pattern_classifier
package vipc_pkg;

  localparam int IDX_W    = 31;
  localparam int LANE_MAX = 8;
  localparam int OFF_W    = 3;
  localparam int CLASS_W  = 2;
  localparam int MASK_W   = 11;
  localparam int LEVEL_W  = 4;
  localparam int OFFS_W   = LANE_MAX * OFF_W;
  localparam int TYPE_W   = 3;

  // index class codes
  localparam logic [CLASS_W-1:0] CLS_EQUAL    = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_ASC      = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_DISORDER = 2'd2;

  // type codes carried above the lane bits of the pattern mask
  localparam logic [TYPE_W-1:0] TYPE_EQUAL    = 3'd5;
  localparam logic [TYPE_W-1:0] TYPE_ASC      = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_DISORDER = 3'd0;

  localparam logic [LEVEL_W-1:0] WINDOW_LEVEL = 4'd1;

  typedef logic [IDX_W-1:0] idx_t;

  // per-vector statistics; step bit i compares lane i-1 with lane i,
  // bit 0 and bits of unused lanes read as equal and not incrementing
  typedef struct packed {
    logic [LANE_MAX-1:0] step_eq;
    logic [LANE_MAX-1:0] step_inc;
    idx_t                lo;
    idx_t                hi;
  } stats_t;

endpackage

// File: rtl/vipc_stats.sv
// vipc_stats: neighbour step flags and min/max tree over one index vector
// depends on vipc_pkg
module vipc_stats #(
  parameter int LANES = 8
) (
  input  vipc_pkg::idx_t   idx [LANES],
  output vipc_pkg::stats_t stats
);

  vipc_pkg::idx_t pad [vipc_pkg::LANE_MAX];
  vipc_pkg::idx_t lo1 [4];
  vipc_pkg::idx_t hi1 [4];
  vipc_pkg::idx_t lo2 [2];
  vipc_pkg::idx_t hi2 [2];
  logic [vipc_pkg::LANE_MAX-1:0] eq;
  logic [vipc_pkg::LANE_MAX-1:0] inc;

  // unused lanes take lane 0 so they never move the min or max
  always_comb begin
    for (int i = 0; i < vipc_pkg::LANE_MAX; i++) begin
      pad[i] = (i < LANES) ? idx[i] : idx[0];
    end
  end

  // step flags between neighbouring lanes
  always_comb begin
    eq  = '1;
    inc = '0;
    for (int i = 1; i < vipc_pkg::LANE_MAX; i++) begin
      if (i < LANES) begin
        eq[i]  = (pad[i-1] == pad[i]);
        inc[i] = ({1'b0, pad[i-1]} + 32'd1) == {1'b0, pad[i]};
      end
    end
  end

  // three-level min/max tree
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lo1[j] = (pad[2*j+1] < pad[2*j]) ? pad[2*j+1] : pad[2*j];
      hi1[j] = (pad[2*j+1] > pad[2*j]) ? pad[2*j+1] : pad[2*j];
    end
    for (int j = 0; j < 2; j++) begin
      lo2[j] = (lo1[2*j+1] < lo1[2*j]) ? lo1[2*j+1] : lo1[2*j];
      hi2[j] = (hi1[2*j+1] > hi1[2*j]) ? hi1[2*j+1] : hi1[2*j];
    end
    stats.lo       = (lo2[1] < lo2[0]) ? lo2[1] : lo2[0];
    stats.hi       = (hi2[1] > hi2[0]) ? hi2[1] : hi2[0];
    stats.step_eq  = eq;
    stats.step_inc = inc;
  end

endmodule

// File: rtl/vector_index_pattern_classifier.sv
// vector_index_pattern_classifier: input register, classification logic, result register.
// A vector taken into the input register reaches the outputs through the result register.
// Throughput: one vector per cycle; the input register advances when it is empty or the result is free.
// Stall on the output reaches the input through the ready chain in the same cycle.
// Reset (rst, synchronous, active high) empties both registers and clears scatter_mode.
// depends on vipc_pkg and vipc_stats
module vector_index_pattern_classifier #(
  parameter int LANES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane0,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane1,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane2,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane3,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane4,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane5,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane6,
  input  logic [vipc_pkg::IDX_W-1:0]     index_lane7,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vipc_pkg::CLASS_W-1:0]   index_class,
  output logic [vipc_pkg::MASK_W-1:0]    pattern_mask,
  output logic [vipc_pkg::IDX_W-1:0]     base_index,
  output logic [vipc_pkg::LEVEL_W-1:0]   level,
  output logic [vipc_pkg::OFFS_W-1:0]    lane_offsets,
  output logic                           full_gather
);

  vipc_pkg::idx_t   in_lanes [vipc_pkg::LANE_MAX];
  vipc_pkg::idx_t   s1_idx [LANES];
  vipc_pkg::stats_t s1_stats;
  logic             s1_valid;
  logic             scatter_mode;
  logic             rdy_out;
  logic             rdy1;

  logic [vipc_pkg::CLASS_W-1:0] class_next;
  logic [vipc_pkg::MASK_W-1:0]  mask_next;
  vipc_pkg::idx_t               base_next;
  logic [vipc_pkg::LEVEL_W-1:0] level_next;
  logic [vipc_pkg::OFFS_W-1:0]  offs_next;
  logic                         full_next;

  assign in_lanes[0] = index_lane0;
  assign in_lanes[1] = index_lane1;
  assign in_lanes[2] = index_lane2;
  assign in_lanes[3] = index_lane3;
  assign in_lanes[4] = index_lane4;
  assign in_lanes[5] = index_lane5;
  assign in_lanes[6] = index_lane6;
  assign in_lanes[7] = index_lane7;

  // ready chain
  assign rdy_out  = !out_valid || !out_stall;
  assign rdy1     = !s1_valid || rdy_out;
  assign in_stall = !rdy1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scatter_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      scatter_mode <= cfg_wr_data;
    end
  end

  // register valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= in_valid;
      end
      if (rdy_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  // input register on each transfer
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int i = 0; i < LANES; i++) begin
        s1_idx[i] <= in_lanes[i];
      end
    end
  end

  vipc_stats #(
    .LANES (LANES)
  ) u_stats (
    .idx   (s1_idx),
    .stats (s1_stats)
  );

  // classification and window offsets
  always_comb begin
    logic [vipc_pkg::LANE_MAX-1:0] change;
    vipc_pkg::idx_t                span;
    logic                          window;

    change = ~s1_stats.step_eq | vipc_pkg::LANE_MAX'(1);
    span   = s1_stats.hi - s1_stats.lo;
    window = !scatter_mode && (span < vipc_pkg::IDX_W'(LANES));

    base_next  = s1_idx[0];
    level_next = vipc_pkg::WINDOW_LEVEL;
    offs_next  = '0;
    full_next  = 1'b0;

    if (&s1_stats.step_eq) begin
      class_next = vipc_pkg::CLS_EQUAL;
      mask_next  = vipc_pkg::MASK_W'(1)
                 | (vipc_pkg::MASK_W'(vipc_pkg::TYPE_EQUAL) << LANES);
    end else if (&(s1_stats.step_eq | s1_stats.step_inc)) begin
      class_next = vipc_pkg::CLS_ASC;
      mask_next  = vipc_pkg::MASK_W'(change)
                 | (vipc_pkg::MASK_W'(vipc_pkg::TYPE_ASC) << LANES);
    end else begin
      class_next = vipc_pkg::CLS_DISORDER;
      if (window) begin
        base_next = s1_stats.lo;
        // offset fits three bits inside a window, so low bits suffice
        for (int i = 0; i < LANES; i++) begin
          offs_next[vipc_pkg::OFF_W*i +: vipc_pkg::OFF_W] =
            s1_idx[i][vipc_pkg::OFF_W-1:0] - s1_stats.lo[vipc_pkg::OFF_W-1:0];
        end
      end else begin
        level_next = vipc_pkg::LEVEL_W'(LANES);
        full_next  = 1'b1;
      end
      mask_next = vipc_pkg::MASK_W'(level_next)
                | (vipc_pkg::MASK_W'(vipc_pkg::TYPE_DISORDER) << LANES);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rdy_out && s1_valid) begin
      index_class  <= class_next;
      pattern_mask <= mask_next;
      base_index   <= base_next;
      level        <= level_next;
      lane_offsets <= offs_next;
      full_gather  <= full_next;
    end
  end

`ifndef SYNTHESIS
  // a free output never holds back the input
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output side is free");

  // full gather only for disorder at full level
  a_full_gather_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_gather |->
      (level == vipc_pkg::LEVEL_W'(LANES)) && (index_class == vipc_pkg::CLS_DISORDER))
    else $error("full gather with wrong level or class");

  // offsets only appear for a single window
  a_offsets_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lane_offsets != '0) |->
      (index_class == vipc_pkg::CLS_DISORDER) && !full_gather && !scatter_mode)
    else $error("lane offsets outside a gather window");

  // a vector in the input register reaches the output once it is free
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rdy_out |=> out_valid)
    else $error("result lost between input and output register");
`endif

endmodule

// File: verif/vector_index_pattern_classifier_tb.sv
// testbench for vector_index_pattern_classifier: directed and random index vectors under
// random valid and stall gaps, each result checked against an in-bench classifier
// depends on vipc_pkg and the vector_index_pattern_classifier rtl
module vector_index_pattern_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LANES = 8;
  localparam int MAX_REPORTS = 10;
  localparam vipc_pkg::idx_t IDX_TOP = '1;

  typedef logic [LANES-1:0][vipc_pkg::IDX_W-1:0] vec_t;

  typedef struct packed {
    logic [vipc_pkg::CLASS_W-1:0] cls;
    logic [vipc_pkg::MASK_W-1:0]  mask;
    vipc_pkg::idx_t               base;
    logic [vipc_pkg::LEVEL_W-1:0] lvl;
    logic [vipc_pkg::OFFS_W-1:0]  offs;
    logic                         full;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [vipc_pkg::IDX_W-1:0] index_lane0 = '0, index_lane1 = '0;
  logic [vipc_pkg::IDX_W-1:0] index_lane2 = '0, index_lane3 = '0;
  logic [vipc_pkg::IDX_W-1:0] index_lane4 = '0, index_lane5 = '0;
  logic [vipc_pkg::IDX_W-1:0] index_lane6 = '0, index_lane7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [vipc_pkg::CLASS_W-1:0] index_class;
  logic [vipc_pkg::MASK_W-1:0]  pattern_mask;
  logic [vipc_pkg::IDX_W-1:0]   base_index;
  logic [vipc_pkg::LEVEL_W-1:0] level;
  logic [vipc_pkg::OFFS_W-1:0]  lane_offsets;
  logic                         full_gather;

  vec_t     vectors_to_send[$];
  verdict_t awaited_verdicts[$];
  logic     scatter_copy = 1'b0;
  logic     quiet = 1'b0;
  logic     in_taken = 1'b0;
  int       send_gap = 0;
  int       stall_left = 0;
  int       mismatches = 0;
  int       unexpected = 0;
  vec_t     seen_vec;
  verdict_t got, want;

  vector_index_pattern_classifier #(.LANES(LANES)) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .index_lane0(index_lane0), .index_lane1(index_lane1),
    .index_lane2(index_lane2), .index_lane3(index_lane3),
    .index_lane4(index_lane4), .index_lane5(index_lane5),
    .index_lane6(index_lane6), .index_lane7(index_lane7),
    .out_valid(out_valid), .out_stall(out_stall),
    .index_class(index_class), .pattern_mask(pattern_mask), .base_index(base_index),
    .level(level), .lane_offsets(lane_offsets), .full_gather(full_gather)
  );

  initial forever #10 clk = ~clk;

  // expected classification of one index vector
  function automatic verdict_t classify_vector(vec_t v, logic scatter);
    verdict_t r;
    int n_same, n_inc;
    logic [LANES-1:0] chg;
    vipc_pkg::idx_t lo, hi, diff;
    n_same = 0;
    n_inc = 0;
    chg = LANES'(1);
    lo = v[0];
    hi = v[0];
    for (int i = 1; i < LANES; i++) begin
      if (v[i] == v[i-1]) begin
        n_same++;
      end else begin
        chg[i] = 1'b1;
        // no wrap: the top index plus one is not index zero
        if ({1'b0, v[i-1]} + 32'd1 == {1'b0, v[i]}) n_inc++;
      end
      if (v[i] < lo) lo = v[i];
      if (v[i] > hi) hi = v[i];
    end
    r.base = v[0];
    r.offs = '0;
    r.full = 1'b0;
    r.lvl  = vipc_pkg::WINDOW_LEVEL;
    if (n_same == LANES - 1) begin
      r.cls  = vipc_pkg::CLS_EQUAL;
      r.mask = vipc_pkg::MASK_W'(1)
             | (vipc_pkg::MASK_W'(vipc_pkg::TYPE_EQUAL) << LANES);
    end else if (n_same + n_inc == LANES - 1) begin
      r.cls  = vipc_pkg::CLS_ASC;
      r.mask = vipc_pkg::MASK_W'(chg)
             | (vipc_pkg::MASK_W'(vipc_pkg::TYPE_ASC) << LANES);
    end else begin
      r.cls = vipc_pkg::CLS_DISORDER;
      if (!scatter && (hi - lo) < vipc_pkg::idx_t'(LANES)) begin
        // single window: minimum plus per-lane offsets
        r.base = lo;
        for (int i = 0; i < LANES; i++) begin
          diff = v[i] - lo;
          r.offs[vipc_pkg::OFF_W*i +: vipc_pkg::OFF_W] = diff[vipc_pkg::OFF_W-1:0];
        end
      end else begin
        r.lvl  = vipc_pkg::LEVEL_W'(LANES);
        r.full = 1'b1;
      end
      r.mask = vipc_pkg::MASK_W'(r.lvl)
             | (vipc_pkg::MASK_W'(vipc_pkg::TYPE_DISORDER) << LANES);
    end
    return r;
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // indices biased towards both ends of the field
  function automatic vipc_pkg::idx_t pick_index();
    case ($urandom_range(0, 3))
      0:       return vipc_pkg::idx_t'($urandom_range(0, 15));
      1:       return IDX_TOP - vipc_pkg::idx_t'($urandom_range(0, 15));
      default: return vipc_pkg::idx_t'($urandom);
    endcase
  endfunction

  // mostly well-formed equal, run and window vectors, some broken or plain noise
  function automatic vec_t random_vector();
    vec_t v;
    vipc_pkg::idx_t base;
    int kind;
    base = pick_index();
    kind = $urandom_range(0, 99);
    for (int i = 0; i < LANES; i++) begin
      if (kind < 15) v[i] = base;
      else if (kind < 50)
        v[i] = (i == 0) ? base : v[i-1] + vipc_pkg::idx_t'($urandom_range(0, 1));
      else if (kind < 75) v[i] = base + vipc_pkg::idx_t'($urandom_range(0, LANES - 1));
      else if (kind < 85) v[i] = base + vipc_pkg::idx_t'($urandom_range(0, LANES + 1));
      else v[i] = pick_index();
    end
    // broken run: one lane jumps off the sequence
    if (kind >= 35 && kind < 50 && $urandom_range(0, 2) == 0)
      v[$urandom_range(1, LANES - 1)] += vipc_pkg::idx_t'($urandom_range(2, 3));
    return v;
  endfunction

  function automatic vec_t fill_vec(int a0, int a1, int a2, int a3,
                                    int a4, int a5, int a6, int a7);
    return {vipc_pkg::idx_t'(a7), vipc_pkg::idx_t'(a6), vipc_pkg::idx_t'(a5),
            vipc_pkg::idx_t'(a4), vipc_pkg::idx_t'(a3), vipc_pkg::idx_t'(a2),
            vipc_pkg::idx_t'(a1), vipc_pkg::idx_t'(a0)};
  endfunction

  // append one vector to the pending queue
  function automatic void add_vector(vec_t v);
    vectors_to_send.insert(vectors_to_send.size(), v);
  endfunction

  task automatic queue_directed();
    int top;
    int t;
    top = int'(IDX_TOP);
    t = top - (LANES - 1);
    add_vector('0);
    add_vector({LANES{IDX_TOP - vipc_pkg::idx_t'(1)}});
    add_vector({LANES{IDX_TOP}});
    add_vector(fill_vec(0, 1, 2, 3, 4, 5, 6, 7));
    add_vector(fill_vec(5, 5, 6, 6, 6, 7, 8, 8));
    add_vector(fill_vec(0, 1, 1, 1, 1, 1, 1, 1));
    add_vector(fill_vec(4, 4, 4, 4, 4, 4, 4, 5));
    add_vector(fill_vec(t, t+1, t+2, t+3, t+4, t+5, t+6, t+7));
    add_vector(fill_vec(top - 1, top, 0, 1, 2, 3, 4, 5));
    add_vector(fill_vec(3, 1, 0, 2, 7, 4, 6, 5));
    add_vector(fill_vec(t+7, t, t+3, t+6, t+1, t+5, t+2, t+4));
    add_vector(fill_vec(7, 6, 5, 4, 3, 2, 1, 0));
    add_vector(fill_vec(10, 18, 10, 12, 11, 10, 14, 13));
    add_vector(fill_vec(10, 17, 10, 12, 11, 10, 14, 13));
    add_vector(fill_vec(5, 5, 5, 5, 5, 5, 5, 4));
    add_vector(fill_vec(0, 2, 4, 6, 8, 10, 12, 14));
    add_vector(fill_vec(0, top, 0, top, 0, top, 0, top));
    add_vector({LANES/2{vipc_pkg::idx_t'(31'h2AAAAAAA), vipc_pkg::idx_t'(31'h55555555)}});
    add_vector(fill_vec(9, 9, 9, 8, 9, 9, 9, 9));
    add_vector(fill_vec(1, 2, 3, 4, 5, 6, 7, 6));
  endtask

  // wait until the block holds nothing and no vector is waiting
  task automatic drain();
    while (vectors_to_send.size() != 0 || in_valid || awaited_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_scatter(logic mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    scatter_copy = mode;
  endtask

  // input driver: next vector after a transfer or an idle gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (vectors_to_send.size() != 0) begin
      {index_lane7, index_lane6, index_lane5, index_lane4,
       index_lane3, index_lane2, index_lane1, index_lane0} <= vectors_to_send.pop_front();
      in_valid <= 1'b1;
      send_gap = quiet ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = quiet ? 0 : pick_gap();
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen_vec = {index_lane7, index_lane6, index_lane5, index_lane4,
                    index_lane3, index_lane2, index_lane1, index_lane0};
        awaited_verdicts.insert(awaited_verdicts.size(),
                                classify_vector(seen_vec, scatter_copy));
      end
      if (out_valid && !out_stall) begin
        got = '{index_class, pattern_mask, base_index, level, lane_offsets, full_gather};
        if (awaited_verdicts.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= MAX_REPORTS)
            $display("unexpected result: class %0d mask %h base %h", got.cls, got.mask,
                     got.base);
        end else begin
          want = awaited_verdicts.pop_front();
          if (got.cls != want.cls || got.mask != want.mask || got.base != want.base ||
              got.lvl != want.lvl || got.offs != want.offs || got.full != want.full) begin
            mismatches++;
            if (mismatches + unexpected <= MAX_REPORTS) begin
              $display("mismatch expected: class %0d mask %h base %h level %0d offs %h full %b",
                       want.cls, want.mask, want.base, want.lvl, want.offs, want.full);
              $display("         actual:   class %0d mask %h base %h level %0d offs %h full %b",
                       got.cls, got.mask, got.base, got.lvl, got.offs, got.full);
            end
          end
        end
      end
    end
  end

  // stimulus phases, each under one scatter setting
  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    write_scatter(1'b0);
    queue_directed();
    drain();
    write_scatter(1'b1);
    queue_directed();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_scatter(ph[0]);
      quiet = (ph == 2 || ph == 5);
      repeat ((ph < 3) ? 380 : 150) add_vector(random_vector());
      drain();
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && unexpected == 0 && awaited_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: vector_index_pattern_classifier.f
rtl/vipc_pkg.sv
rtl/vipc_stats.sv
rtl/vector_index_pattern_classifier.sv
verif/vector_index_pattern_classifier_tb.sv
